FILE: rtl/core/baro_pressure_temp_compensation_assert.svh
// ---------------------------------------------------------------------------
// Barometric compensation assertion macros
// Shared assertion forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// An implication checked at every clock edge outside reset.
`define BARO_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// An implication checked at the clock edge that follows.
`define BARO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/bpc_pkg.sv
// ---------------------------------------------------------------------------
// Barometric compensation package
// Request and response types, register indexes, pipeline constants and shift helpers.
// ---------------------------------------------------------------------------
package bpc_pkg;

   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 64;
   localparam int unsigned DivStages    = 32;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_TEMP_CAL   = 2'd0,
      REG_PRES_CAL_LO = 2'd1,
      REG_PRES_CAL_HI = 2'd2,
      REG_PRES_CAL_P9 = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
   } request_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_pa;
      logic               pressure_valid;
   } response_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      logic signed [31:0] s;
      s = $signed(x);
      return 32'(s >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

FILE: rtl/core/baro_pressure_temp_compensation.sv
// Pipeline: 47 register stages from the accepting edge to the response strobe.
// Throughput: one request per cycle; the 32-stage restoring divider sets depth.
// Every stage is pipelined, one quotient bit per divider stage.
// Synchronous active-high reset clears valid bits and calibration to zero.
// The receiver cannot stall; each response is shown for one cycle.
// ---------------------------------------------------------------------------
// Barometric pressure and temperature compensation
// Deep pipeline for the 32-bit integer compensation with a pipelined divider.
// ---------------------------------------------------------------------------
`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  bpc_pkg::request_type                 req_data,
   output logic                                 rsp_strobe,
   output bpc_pkg::response_type                rsp_data,
   input  logic                                 csr_write,
   input  logic [bpc_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [bpc_pkg::CsrDataWidth-1:0]     csr_data
);

   localparam int unsigned DIV_STAGES = bpc_pkg::DivStages;
   localparam int unsigned PreStages = 13;
   localparam int unsigned PostStages = 2;

   logic [47:0] tcal_ff;
   logic [63:0] pcal_lo_ff;
   logic [63:0] pcal_hi_ff;
   logic [15:0] p9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff    <= '0;
         pcal_lo_ff <= '0;
         pcal_hi_ff <= '0;
         p9_ff      <= '0;
      end else if (csr_write) begin
         unique case (bpc_pkg::reg_index_type'(csr_index))
            bpc_pkg::REG_TEMP_CAL:    tcal_ff    <= csr_data[47:0];
            bpc_pkg::REG_PRES_CAL_LO: pcal_lo_ff <= csr_data;
            bpc_pkg::REG_PRES_CAL_HI: pcal_hi_ff <= csr_data;
            bpc_pkg::REG_PRES_CAL_P9: p9_ff      <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'd0, tcal_ff[15:0]};
   assign t2 = bpc_pkg::sx16(tcal_ff[31:16]);
   assign t3 = bpc_pkg::sx16(tcal_ff[47:32]);
   assign p1 = {16'd0, pcal_lo_ff[15:0]};
   assign p2 = bpc_pkg::sx16(pcal_lo_ff[31:16]);
   assign p3 = bpc_pkg::sx16(pcal_lo_ff[47:32]);
   assign p4 = bpc_pkg::sx16(pcal_lo_ff[63:48]);
   assign p5 = bpc_pkg::sx16(pcal_hi_ff[15:0]);
   assign p6 = bpc_pkg::sx16(pcal_hi_ff[31:16]);
   assign p7 = bpc_pkg::sx16(pcal_hi_ff[47:32]);
   assign p8 = bpc_pkg::sx16(pcal_hi_ff[63:48]);
   assign p9 = bpc_pkg::sx16(p9_ff);

   assign busy = 1'b0;

   // Front section: temperature and pressure arithmetic split over registered stages.
   logic [PreStages-1:0] pv_ff;
   logic [19:0] adcp_ff [PreStages];
   logic [31:0] x_ff [PreStages];
   logic [31:0] y_ff [PreStages];
   logic [31:0] fine_ff [PreStages];
   logic [31:0] temp_ff [PreStages];
   logic [31:0] pa_ff [PreStages];
   logic [31:0] pq_ff [PreStages];
   logic [31:0] pb_ff [PreStages];
   logic [31:0] x_in [PreStages];
   logic [31:0] y_in [PreStages];
   logic [31:0] fine_in [PreStages];
   logic [31:0] temp_in [PreStages];
   logic [31:0] pa_in [PreStages];
   logic [31:0] pq_in [PreStages];
   logic [31:0] pb_in [PreStages];
   logic        hi_ff;

   logic [31:0] adc_t;
   assign adc_t = {12'd0, req_data.raw_temperature};

   always_comb begin
      for (int s = 0; s < PreStages; s++) begin
         x_in[s] = '0; y_in[s] = '0; fine_in[s] = '0; temp_in[s] = '0;
         pa_in[s] = '0; pq_in[s] = '0; pb_in[s] = '0;
         if (s > 0) begin
            x_in[s] = x_ff[s-1]; y_in[s] = y_ff[s-1]; fine_in[s] = fine_ff[s-1];
            temp_in[s] = temp_ff[s-1]; pa_in[s] = pa_ff[s-1];
            pq_in[s] = pq_ff[s-1]; pb_in[s] = pb_ff[s-1];
         end
      end
      x_in[0] = (adc_t >> 3) - (t1 << 1);
      y_in[0] = (adc_t >> 4) - t1;
      x_in[1] = bpc_pkg::asr(x_ff[0] * t2, 11);
      y_in[1] = y_ff[0] * y_ff[0];
      y_in[2] = bpc_pkg::asr(y_ff[1], 12) * t3;
      fine_in[3] = x_ff[2] + bpc_pkg::asr(y_ff[2], 14);
      temp_in[4] = fine_ff[3] * 32'd5 + 32'd128;
      pa_in[4] = bpc_pkg::asr(fine_ff[3], 1) - 32'd64000;
      temp_in[5] = bpc_pkg::asr(temp_ff[4], 8);
      pq_in[5] = bpc_pkg::asr(pa_ff[4], 2);
      pq_in[6] = pq_ff[5] * pq_ff[5];
      x_in[6] = pa_ff[5] * p5;
      y_in[6] = p2 * pa_ff[5];
      pb_in[7] = bpc_pkg::asr(pq_ff[6], 11) * p6;
      pq_in[7] = p3 * bpc_pkg::asr(pq_ff[6], 13);
      pb_in[8] = bpc_pkg::asr(pb_ff[7] + (x_ff[7] << 1), 2) + (p4 << 16);
      pa_in[8] = bpc_pkg::asr(bpc_pkg::asr(pq_ff[7], 3) + bpc_pkg::asr(y_ff[7], 1), 18);
      pa_in[9] = (32'd32768 + pa_ff[8]) * p1;
      pa_in[10] = bpc_pkg::asr(pa_ff[9], 15);
      pb_in[10] = (32'd1048576 - {12'd0, adcp_ff[9]}) - bpc_pkg::asr(pb_ff[9], 12);
      pb_in[11] = pb_ff[10] * 32'd3125;
      pb_in[12] = pb_ff[11][31] ? pb_ff[11] : (pb_ff[11] << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) pv_ff <= '0;
      else pv_ff <= {pv_ff[PreStages-2:0], start};
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < PreStages; s++) begin
         if (s == 0) adcp_ff[s] <= req_data.raw_pressure;
         else adcp_ff[s] <= adcp_ff[s-1];
         x_ff[s] <= x_in[s]; y_ff[s] <= y_in[s]; fine_ff[s] <= fine_in[s];
         temp_ff[s] <= temp_in[s]; pa_ff[s] <= pa_in[s];
         pq_ff[s] <= pq_in[s]; pb_ff[s] <= pb_in[s];
      end
      hi_ff <= pb_ff[PreStages-2][31];
   end

   // Restoring divider, one quotient bit per stage.
   logic [DIV_STAGES-1:0] dv_ff;
   logic [31:0] dn_ff [DIV_STAGES];
   logic [31:0] dd_ff [DIV_STAGES];
   logic [32:0] dr_ff [DIV_STAGES];
   logic [31:0] dq_ff [DIV_STAGES];
   logic        dhi_ff [DIV_STAGES];
   logic [31:0] dt_ff [DIV_STAGES];
   logic [32:0] rs_in [DIV_STAGES];
   logic [32:0] rd_in [DIV_STAGES];

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            rs_in[s] = {32'd0, pb_ff[PreStages-1][31]};
            rd_in[s] = {1'b0, pa_ff[PreStages-1]};
         end else begin
            rs_in[s] = {dr_ff[s-1][31:0], dn_ff[s-1][31]};
            rd_in[s] = {1'b0, dd_ff[s-1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_ff <= '0;
      else dv_ff <= {dv_ff[DIV_STAGES-2:0], pv_ff[PreStages-1]};
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            dn_ff[s]  <= pb_ff[PreStages-1] << 1;
            dd_ff[s]  <= pa_ff[PreStages-1];
            dq_ff[s]  <= {31'd0, rs_in[s] >= rd_in[s]};
            dhi_ff[s] <= hi_ff;
            dt_ff[s]  <= temp_ff[PreStages-1];
         end else begin
            dn_ff[s]  <= dn_ff[s-1] << 1;
            dd_ff[s]  <= dd_ff[s-1];
            dq_ff[s]  <= {dq_ff[s-1][30:0], rs_in[s] >= rd_in[s]};
            dhi_ff[s] <= dhi_ff[s-1];
            dt_ff[s]  <= dt_ff[s-1];
         end
         dr_ff[s] <= (rs_in[s] >= rd_in[s]) ? rs_in[s] - rd_in[s] : rs_in[s];
      end
   end

   // Final correction: two stages.
   logic [PostStages-1:0] ov_ff;
   logic [31:0] fp_ff, fa_ff, fb_ff, ftemp_ff, ftemp2_ff, fres_ff;
   logic        fok_ff, fok2_ff;
   logic [31:0] qdiv, fq;
   logic [31:0] fp_in, fq_in;

   assign qdiv = dhi_ff[DIV_STAGES-1] ? (dq_ff[DIV_STAGES-1] << 1) : dq_ff[DIV_STAGES-1];
   assign fp_in = qdiv;
   assign fq = qdiv >> 3;
   assign fq_in = fq * fq;

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= '0;
      else ov_ff <= {ov_ff[PostStages-2:0], dv_ff[DIV_STAGES-1]};
   end

   always_ff @(posedge clock) begin
      fp_ff    <= fp_in;
      fa_ff    <= fq_in;
      fb_ff    <= (fp_in >> 2) * p8;
      ftemp_ff <= dt_ff[DIV_STAGES-1];
      fok_ff   <= dd_ff[DIV_STAGES-1] != 32'd0;
      fres_ff  <= fp_ff + bpc_pkg::asr(bpc_pkg::asr(p9 * (fa_ff >> 13), 12)
                 + bpc_pkg::asr(fb_ff, 13) + p7, 4);
      ftemp2_ff <= ftemp_ff;
      fok2_ff   <= fok_ff;
   end

   assign rsp_strobe = ov_ff[PostStages-1];
   assign rsp_data.temperature_centi = $signed(ftemp2_ff);
   assign rsp_data.pressure_pa = fok2_ff ? fres_ff : 32'd0;
   assign rsp_data.pressure_valid = fok2_ff;

   `BARO_ASSERT_NEXT(a_busy_low, clock, reset, 1'b1, busy == 1'b0, "busy must stay low")
   `BARO_ASSERT_IMP(a_valid_zero, clock, reset, rsp_strobe && !rsp_data.pressure_valid,
      rsp_data.pressure_pa == 32'd0, "invalid pressure must be zero")
   `BARO_ASSERT_NEXT(a_strobe_follow, clock, reset, dv_ff[DIV_STAGES-1], ov_ff[0],
      "divider output lost")

endmodule
